### rtl/core/pntc_pkg.sv
package pntc_pkg;

    // Pattern geometry
    localparam int CELLS_PER_PATTERN_DEF = 256;
    localparam int CNT_W                 = 9;

    // Stream codes
    localparam logic       OP_DATA       = 1'b0;
    localparam logic       OP_NEW_PAT    = 1'b1;
    localparam logic [7:0] EMPTY_NOTE    = 8'h80;
    localparam logic [3:0] FX_SET_VOLUME = 4'hC;

    // Byte phase codes
    localparam logic [1:0] PH_NOTE_START = 2'd0;
    localparam logic [1:0] PH_LAST_BYTE  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_index;
        logic [7:0] cell_byte0;
        logic [7:0] cell_byte1;
        logic [7:0] cell_byte2;
        logic [7:0] cell_byte3;
        logic       last_cell;
    } t_out_item;

    // Decimal-coded byte to binary: high digit * 10 + low digit
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
    endfunction

endpackage

### rtl/core/pntc_in_stage.sv
module pntc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pntc_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output pntc_pkg::t_in_item o_item
);

    logic               r_v;
    logic               n_v;
    pntc_pkg::t_in_item r_item;

    assign o_ready = !r_v || i_take;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_comb begin
        n_v = r_v;
        if (i_valid && o_ready) begin
            n_v = 1'b1;
        end else if (i_take) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // Capture on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/pntc_cell_unit.sv
module pntc_cell_unit #(
    parameter int CELLS_PER_PATTERN = pntc_pkg::CELLS_PER_PATTERN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pntc_pkg::t_in_item i_item,
    input  logic               i_slot_free,
    output logic               o_take,
    output logic               o_res_valid,
    output pntc_pkg::t_out_item o_res
);

    localparam logic [pntc_pkg::CNT_W-1:0] CNT_FULL = pntc_pkg::CNT_W'(CELLS_PER_PATTERN);
    localparam logic [pntc_pkg::CNT_W-1:0] CNT_LAST = pntc_pkg::CNT_W'(CELLS_PER_PATTERN - 1);
    localparam logic [pntc_pkg::CNT_W-1:0] CNT_ONE  = pntc_pkg::CNT_W'(1);

    logic [1:0]                r_phase;
    logic [pntc_pkg::CNT_W-1:0] r_cnt;
    logic [7:0]                r_held [3];

    logic [1:0]                n_phase;
    logic [pntc_pkg::CNT_W-1:0] n_cnt;
    logic                      fire;
    logic                      hold_byte;
    logic [7:0]                smp;
    logic [7:0]                db;

    assign fire   = i_valid && i_slot_free;
    assign o_take = i_slot_free;
    assign db     = i_item.data_byte;

    // Sample number rebuilt from both high nibbles, divided by four
    assign smp = 8'(({4'b0000, r_held[2][7:4]} + {r_held[0][7:4], 4'b0000}) >> 2);

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        hold_byte   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.cell_index = r_cnt[7:0];
        o_res.last_cell  = (r_cnt == CNT_LAST);
        if (fire) begin
            priority if (i_item.op == pntc_pkg::OP_NEW_PAT) begin
                n_phase = pntc_pkg::PH_NOTE_START;
                n_cnt   = '0;
            end else if (r_cnt >= CNT_FULL) begin
                // drop bytes past a full pattern
            end else if (r_phase == pntc_pkg::PH_NOTE_START && db == pntc_pkg::EMPTY_NOTE) begin
                o_res_valid = 1'b1;
                n_cnt       = r_cnt + CNT_ONE;
            end else if (r_phase != pntc_pkg::PH_LAST_BYTE) begin
                hold_byte = 1'b1;
                n_phase   = r_phase + 2'd1;
            end else begin
                o_res_valid      = 1'b1;
                n_cnt            = r_cnt + CNT_ONE;
                n_phase          = pntc_pkg::PH_NOTE_START;
                o_res.cell_byte0 = {smp[7:4], r_held[0][3:0]};
                o_res.cell_byte1 = r_held[1];
                o_res.cell_byte2 = {smp[3:0], r_held[2][3:0]};
                o_res.cell_byte3 = (r_held[2][3:0] == pntc_pkg::FX_SET_VOLUME)
                                 ? pntc_pkg::bcd_to_bin(db) : db;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pntc_pkg::PH_NOTE_START;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_byte) begin
            r_held[r_phase] <= db;
        end
    end

endmodule

### rtl/core/pntc_out_stage.sv
module pntc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  pntc_pkg::t_out_item i_res,
    output logic                o_slot_free,
    output logic                o_valid,
    input  logic                i_ready,
    output pntc_pkg::t_out_item o_item
);

    logic                r_v;
    logic                n_v;
    pntc_pkg::t_out_item r_item;

    assign o_slot_free = !r_v || i_ready;
    assign o_valid     = r_v;
    assign o_item      = r_item;

    always_comb begin
        n_v = r_v;
        if (i_load) begin
            n_v = 1'b1;
        end else if (i_ready) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

### rtl/core/packed_note_to_tracker_cell_core.sv
// Channel   Direction  Handshake          Payload
// --------  ---------  -----------------  -----------------------------------------
// input     in         i_valid / o_ready  i_item: op, data_byte
// result    out        o_valid / i_ready  o_item: cell_index, cell_byte0..3, last_cell
//
// One item per cycle sustained while i_ready stays high; o_valid rises once the item that
// completes its cell has passed the input register and then been loaded into the result register.
// The byte phase, held bytes and cell counter update in one pass per item.
// Reset (synchronous, active low) empties both registers and starts a new pattern.
// A stalled result register holds the slot; the input register then fills and
// o_ready drops until i_ready frees the slot.
module packed_note_to_tracker_cell_core #(
    parameter int CELLS_PER_PATTERN = pntc_pkg::CELLS_PER_PATTERN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pntc_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output pntc_pkg::t_out_item o_item
);

    logic                w_in_v;
    pntc_pkg::t_in_item  w_in_item;
    logic                w_take;
    logic                w_slot_free;
    logic                w_res_v;
    pntc_pkg::t_out_item w_res;

    // Input register: decouple the upstream handshake
    pntc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (w_in_v),
        .i_take  (w_take),
        .o_item  (w_in_item)
    );

    // Advance phase and counter, build the cell when a note completes
    pntc_cell_unit #(
        .CELLS_PER_PATTERN (CELLS_PER_PATTERN)
    ) u_cell (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_v),
        .i_item      (w_in_item),
        .i_slot_free (w_slot_free),
        .o_take      (w_take),
        .o_res_valid (w_res_v),
        .o_res       (w_res)
    );

    // Result register: hold the cell until taken
    pntc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_v),
        .i_res       (w_res),
        .o_slot_free (w_slot_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    // A shown cell never lies past the end of the pattern
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (9'(o_item.cell_index) <= 9'(CELLS_PER_PATTERN - 1)))
        else $error("cell index beyond pattern");

    // last_cell flags exactly the final index
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_cell == (9'(o_item.cell_index) == 9'(CELLS_PER_PATTERN - 1))))
        else $error("last_cell disagrees with cell index");

    // Both registers full and result stalled: no new item may enter
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_v && o_valid && !i_ready) |-> !o_ready)
        else $error("item accepted while pipeline is blocked");

    // A result is loaded only into a free slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_res_v)
        else $error("result overwrites a pending cell");

endmodule

### dv/tracker_cell_checker.sv
module tracker_cell_checker #(
    parameter int CELLS = pntc_pkg::CELLS_PER_PATTERN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  pntc_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pntc_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]          note_phase;
    logic [7:0]          note_bytes [3];
    logic [8:0]          cells_emitted;
    pntc_pkg::t_out_item expected_cells [$];
    pntc_pkg::t_out_item next_cell;

    function automatic void clear_pattern();
        note_phase    = pntc_pkg::PH_NOTE_START;
        note_bytes    = '{default: '0};
        cells_emitted = '0;
    endfunction

    function automatic pntc_pkg::t_out_item make_cell(input logic [7:0] b0,
                                                      input logic [7:0] b1,
                                                      input logic [7:0] b2,
                                                      input logic [7:0] b3);
        pntc_pkg::t_out_item built;
        built.cell_index = cells_emitted[7:0];
        built.cell_byte0 = b0;
        built.cell_byte1 = b1;
        built.cell_byte2 = b2;
        built.cell_byte3 = b3;
        built.last_cell  = (int'(cells_emitted) + 1 == CELLS);
        cells_emitted    = cells_emitted + 9'd1;
        return built;
    endfunction

    // Advance the unpacker by one byte; return 1 when a cell comes out.
    function automatic bit unpack_byte(input pntc_pkg::t_in_item it,
                                       output pntc_pkg::t_out_item res);
        int         sample;
        logic [7:0] smp;
        logic [7:0] arg;
        res = '0;
        if (it.op == pntc_pkg::OP_NEW_PAT) begin
            clear_pattern();
            return 1'b0;
        end
        if (int'(cells_emitted) >= CELLS) return 1'b0;
        if (note_phase == pntc_pkg::PH_NOTE_START && it.data_byte == pntc_pkg::EMPTY_NOTE) begin
            res = make_cell(8'h00, 8'h00, 8'h00, 8'h00);
            return 1'b1;
        end
        if (note_phase != pntc_pkg::PH_LAST_BYTE) begin
            note_bytes[note_phase] = it.data_byte;
            note_phase = note_phase + 2'd1;
            return 1'b0;
        end
        note_phase = pntc_pkg::PH_NOTE_START;
        // sample number is split across both high nibbles, scaled down by four
        sample = (int'(note_bytes[2][7:4]) + int'({note_bytes[0][7:4], 4'h0})) / 4;
        smp    = 8'(sample);
        arg    = it.data_byte;
        if (note_bytes[2][3:0] == pntc_pkg::FX_SET_VOLUME)
            arg = 8'(int'(it.data_byte[7:4]) * 10 + int'(it.data_byte[3:0]));
        res = make_cell({smp[7:4], note_bytes[0][3:0]}, note_bytes[1],
                        {smp[3:0], note_bytes[2][3:0]}, arg);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_cell(input pntc_pkg::t_out_item got);
        pntc_pkg::t_out_item want;
        if (expected_cells.size() == 0) begin
            report_mismatch("unexpected cell index", int'(got.cell_index), -1);
            return;
        end
        want = expected_cells.pop_front();
        if (got.cell_index !== want.cell_index)
            report_mismatch("cell_index", int'(got.cell_index), int'(want.cell_index));
        if (got.cell_byte0 !== want.cell_byte0)
            report_mismatch("cell_byte0", int'(got.cell_byte0), int'(want.cell_byte0));
        if (got.cell_byte1 !== want.cell_byte1)
            report_mismatch("cell_byte1", int'(got.cell_byte1), int'(want.cell_byte1));
        if (got.cell_byte2 !== want.cell_byte2)
            report_mismatch("cell_byte2", int'(got.cell_byte2), int'(want.cell_byte2));
        if (got.cell_byte3 !== want.cell_byte3)
            report_mismatch("cell_byte3", int'(got.cell_byte3), int'(want.cell_byte3));
        if (got.last_cell !== want.last_cell)
            report_mismatch("last_cell", int'(got.last_cell), int'(want.last_cell));
    endtask

    // Compare before predicting: a cell leaving now never stems from a byte entering now.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pattern();
        end else begin
            if (i_out_valid && i_out_ready) check_cell(i_out_item);
            if (i_in_valid && i_in_ready && unpack_byte(i_in_item, next_cell))
                expected_cells.push_back(next_cell);
        end
        o_pending = expected_cells.size();
    end

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS       = pntc_pkg::CELLS_PER_PATTERN_DEF;
    localparam int ITEM_TARGET = 950;
    // ~950 items, each at worst behind the longest drawn input gap plus the longest drawn result stall
    localparam int CYCLE_LIMIT = 300000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    pntc_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_ready;
    pntc_pkg::t_out_item o_item;

    int fail_count;
    int cells_pending;
    int cycle_count;
    int items_sent;

    // pacing state: each side alternates calm stretches with random idling
    int send_left;
    int recv_left;
    bit send_calm;
    bit recv_calm;

    packed_note_to_tracker_cell_core #(
        .CELLS_PER_PATTERN(CELLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    tracker_cell_checker #(
        .CELLS(CELLS)
    ) checker_0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_item   (i_item),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_item  (o_item),
        .o_fail_count(fail_count),
        .o_pending   (cells_pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if it hangs anywhere.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Draw the idle cycles before the next item; flip between calm and busy now and then.
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Result side: stall for a drawn number of cycles, then take one cell.
    initial begin
        int w;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            w = draw_wait(recv_left, recv_calm);
            if (w > 0) begin
                i_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    // Drive one item at a falling edge and hold it until the block takes it.
    // Keep valid high between items when no gap is drawn.
    task automatic send_item(input logic op, input logic [7:0] data);
        int                 w;
        pntc_pkg::t_in_item it;
        w = draw_wait(send_left, send_calm);
        if (w > 0) begin
            i_valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        it.op        = op;
        it.data_byte = data;
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    // One note: either the empty-note byte or four bytes. Optionally cut it short
    // and start a new pattern, which must drop the partial note.
    task automatic send_note(input bit allow_cut, input int empty_in_four);
        logic [7:0] b;
        int         cut;
        if ($urandom_range(1, 4) <= empty_in_four) begin
            send_item(pntc_pkg::OP_DATA, pntc_pkg::EMPTY_NOTE);
            return;
        end
        cut = (allow_cut && $urandom_range(0, 29) == 0) ? $urandom_range(1, 3) : 4;
        for (int k = 0; k < cut; k++) begin
            b = 8'($urandom);
            // steer a fair share of notes onto the decimal-coded volume effect
            if (k == 2 && $urandom_range(0, 3) == 0) b[3:0] = pntc_pkg::FX_SET_VOLUME;
            send_item(pntc_pkg::OP_DATA, b);
        end
        if (cut < 4) send_item(pntc_pkg::OP_NEW_PAT, 8'($urandom));
    endtask

    task automatic send_pattern(input int notes, input bit allow_cut, input int empty_in_four);
        send_item(pntc_pkg::OP_NEW_PAT, 8'($urandom));
        repeat (notes) send_note(allow_cut, empty_in_four);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_ready    = 1'b0;
        items_sent = 0;
        send_left  = 0;
        recv_left  = 0;
        send_calm  = 1'b0;
        recv_calm  = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes before any new-pattern item: reset counts as a pattern start.
        send_item(pntc_pkg::OP_DATA, 8'h12);
        send_item(pntc_pkg::OP_DATA, 8'h34);
        send_item(pntc_pkg::OP_DATA, 8'h56);
        send_item(pntc_pkg::OP_DATA, 8'h78);
        send_item(pntc_pkg::OP_DATA, pntc_pkg::EMPTY_NOTE);
        // New pattern with a nonzero data byte, which must be ignored.
        send_item(pntc_pkg::OP_NEW_PAT, 8'hFF);
        // All ones, with the volume effect and the largest sample number.
        send_item(pntc_pkg::OP_DATA, 8'hFF);
        send_item(pntc_pkg::OP_DATA, 8'hFF);
        send_item(pntc_pkg::OP_DATA, 8'hFC);
        send_item(pntc_pkg::OP_DATA, 8'h99);
        // All zeros.
        repeat (4) send_item(pntc_pkg::OP_DATA, 8'h00);
        // The empty-note byte is plain data past the first position.
        send_item(pntc_pkg::OP_DATA, 8'h01);
        repeat (3) send_item(pntc_pkg::OP_DATA, pntc_pkg::EMPTY_NOTE);
        // Volume effect with an argument that is not valid decimal coding.
        send_item(pntc_pkg::OP_DATA, 8'h0F);
        send_item(pntc_pkg::OP_DATA, 8'h00);
        send_item(pntc_pkg::OP_DATA, 8'hFC);
        send_item(pntc_pkg::OP_DATA, 8'hFF);
        // Unfinished note dropped by a new pattern; the index restarts at zero.
        send_item(pntc_pkg::OP_DATA, 8'h11);
        send_item(pntc_pkg::OP_DATA, 8'h22);
        send_item(pntc_pkg::OP_NEW_PAT, 8'h00);
        send_item(pntc_pkg::OP_DATA, pntc_pkg::EMPTY_NOTE);

        // Fill one pattern past its end: mostly empty notes to keep it short,
        // then extra notes that must be ignored once it is full.
        send_pattern(CELLS + 12, 1'b0, 3);

        // Mostly short well-formed patterns; now and then raw noise of any op.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_item(logic'($urandom_range(0, 7) == 0), 8'($urandom));
            end else begin
                send_pattern($urandom_range(1, 24), 1'b1, 1);
            end
        end
        i_valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray cell.
        while (cells_pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && cells_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### packed_note_to_tracker_cell_core.f
rtl/core/pntc_pkg.sv
rtl/core/pntc_in_stage.sv
rtl/core/pntc_cell_unit.sv
rtl/core/pntc_out_stage.sv
rtl/core/packed_note_to_tracker_cell_core.sv
dv/tracker_cell_checker.sv
dv/testbench.sv
